>>> rtl/bres_pkg.sv
// Package for the Bayer region exposure statistics block.
// Widths, limits, stats record and sequencer states; no dependencies.
package bres_pkg;

    localparam int PIXEL_BITS = 16;
    localparam longint MAX_PIXELS = 64'd16777216;

    localparam int PIX_W    = 16;
    localparam int CH_W     = 2;
    localparam int NUM_CH   = 4;
    localparam int SUM_W    = 40;
    localparam int TALLY_W  = 25;
    localparam int MEAN_W   = 26;
    localparam int MEAN_SHIFT = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = $clog2(MEAN_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_ON_MIS = 2'd2;

    localparam longint TALLY_MAX = (64'd1 << TALLY_W) - 64'd1;
    localparam logic [TALLY_W-1:0] TALLY_CAP =
        TALLY_W'((MAX_PIXELS < TALLY_MAX) ? MAX_PIXELS : TALLY_MAX);

    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [TALLY_W-1:0] tally_t;
    typedef logic [MEAN_W-1:0]  mean_t;

    typedef struct packed {
        logic [NUM_CH-1:0][SUM_W-1:0] sums;
        tally_t below_black;
        tally_t above_white;
        tally_t at_black;
        tally_t at_white;
        tally_t total;
    } stats_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_START,
        ST_DIV,
        ST_OUT
    } seq_state_t;

endpackage

>>> rtl/bres_pix_if.sv
// Pixel input channel: valid/ready handshake with one Bayer pixel per beat.
// Depends on bres_pkg.
interface bres_pix_if;
    logic                          valid;
    logic                          ready;
    logic [bres_pkg::PIX_W-1:0]    pixel_value;
    logic [bres_pkg::CH_W-1:0]     color_index;
    logic                          last_in_region;

    modport source (output valid, pixel_value, color_index, last_in_region, input ready);
    modport sink (input valid, pixel_value, color_index, last_in_region, output ready);
endinterface

>>> rtl/bres_res_if.sv
// Result channel: valid/ready handshake with one region's statistics per beat.
// Depends on bres_pkg.
interface bres_res_if;
    logic                    valid;
    logic                    ready;
    bres_pkg::mean_t         mean_red;
    bres_pkg::mean_t         mean_green_one;
    bres_pkg::mean_t         mean_blue;
    bres_pkg::mean_t         mean_green_two;
    bres_pkg::tally_t        below_black_count;
    bres_pkg::tally_t        above_white_count;
    bres_pkg::tally_t        at_black_count;
    bres_pkg::tally_t        at_white_count;
    logic                    misexposed;
    logic                    exposure_error;

    modport source (output valid, mean_red, mean_green_one, mean_blue, mean_green_two,
                    below_black_count, above_white_count, at_black_count, at_white_count,
                    misexposed, exposure_error, input ready);
    modport sink (input valid, mean_red, mean_green_one, mean_blue, mean_green_two,
                  below_black_count, above_white_count, at_black_count, at_white_count,
                  misexposed, exposure_error, output ready);
endinterface

>>> rtl/bayer_region_exposure_stats_unit.sv
// Bayer region exposure statistics, top level.
// Throughput: one pixel a cycle while accumulating; the last pixel of a region
// is followed by four means from the shared divider, one channel after another,
// and no pixel is taken until the result beat is accepted.
// Reset (rst_n, async): black 0, white 65535, fail off, sums and counts cleared.
// Uses bres_pkg, bres_pix_if, bres_res_if, bres_accum, bres_div.
module bayer_region_exposure_stats_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bres_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bres_pkg::CFG_DATA_W-1:0]    cfg_data,
    bres_pix_if.sink                           pixels,
    bres_res_if.source                         stats
);

    bres_pkg::seq_state_t state_reg, state_next;

    logic [bres_pkg::PIX_W-1:0]   black_reg;
    logic [bres_pkg::PIX_W-1:0]   white_reg;
    logic                         fail_reg;

    logic [bres_pkg::CH_W-1:0]    ch_reg, ch_next;
    bres_pkg::mean_t              mean_reg [bres_pkg::NUM_CH];

    bres_pkg::stats_t             acc;
    logic                         pix_beat;
    logic                         res_beat;
    logic                         div_start;
    logic                         div_done;
    bres_pkg::mean_t              div_q;
    logic                         mis;

    assign pix_beat = pixels.valid && pixels.ready;
    assign res_beat = stats.valid && stats.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_reg <= '0;
            white_reg <= '1;
            fail_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bres_pkg::CFG_BLACK_LEVEL: black_reg <= cfg_data[bres_pkg::PIX_W-1:0];
                bres_pkg::CFG_WHITE_LEVEL: white_reg <= cfg_data[bres_pkg::PIX_W-1:0];
                bres_pkg::CFG_FAIL_ON_MIS: fail_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    bres_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (pix_beat),
        .clear       (res_beat),
        .pixel_value (pixels.pixel_value),
        .color_index (pixels.color_index),
        .black_level (black_reg),
        .white_level (white_reg),
        .stats       (acc)
    );

    bres_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc.sums[ch_reg]),
        .divisor  (acc.total),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        case (state_reg)
            bres_pkg::ST_ACCUM:
            begin
                if (pix_beat && pixels.last_in_region)
                begin
                    state_next = bres_pkg::ST_START;
                    ch_next    = '0;
                end
            end
            bres_pkg::ST_START:
            begin
                state_next = bres_pkg::ST_DIV;
            end
            bres_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (ch_reg == bres_pkg::CH_W'(bres_pkg::NUM_CH - 1))
                    begin
                        state_next = bres_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = bres_pkg::ST_START;
                        ch_next    = ch_reg + 1'b1;
                    end
                end
            end
            bres_pkg::ST_OUT:
            begin
                if (res_beat)
                begin
                    state_next = bres_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = bres_pkg::ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        pixels.ready = 1'b0;
        stats.valid  = 1'b0;
        div_start    = 1'b0;
        case (state_reg)
            bres_pkg::ST_ACCUM: pixels.ready = 1'b1;
            bres_pkg::ST_START: div_start    = 1'b1;
            bres_pkg::ST_DIV:   ;
            bres_pkg::ST_OUT:   stats.valid  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bres_pkg::ST_ACCUM;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bres_pkg::ST_DIV && div_done)
        begin
            mean_reg[ch_reg] <= div_q;
        end
    end

    assign mis = (acc.below_black != '0) || (acc.above_white != '0) ||
                 (acc.at_black != '0) || (acc.at_white != '0);

    assign stats.mean_red          = mean_reg[0];
    assign stats.mean_green_one    = mean_reg[1];
    assign stats.mean_blue         = mean_reg[2];
    assign stats.mean_green_two    = mean_reg[3];
    assign stats.below_black_count = acc.below_black;
    assign stats.above_white_count = acc.above_white;
    assign stats.at_black_count    = acc.at_black;
    assign stats.at_white_count    = acc.at_white;
    assign stats.misexposed        = mis;
    assign stats.exposure_error    = mis && fail_reg;

endmodule

>>> rtl/bres_accum.sv
// Pixel clipping, clip tallies and per-channel black-subtracted sums.
// Depends on bres_pkg.
module bres_accum (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           clear,
    input  logic [bres_pkg::PIX_W-1:0]     pixel_value,
    input  logic [bres_pkg::CH_W-1:0]      color_index,
    input  logic [bres_pkg::PIX_W-1:0]     black_level,
    input  logic [bres_pkg::PIX_W-1:0]     white_level,
    output bres_pkg::stats_t               stats
);

    bres_pkg::stats_t stats_reg;
    bres_pkg::stats_t stats_next;

    logic [bres_pkg::PIX_W-1:0] pix;
    logic [bres_pkg::PIX_W-1:0] clipped;
    logic [bres_pkg::PIX_W-1:0] add;
    logic                       below;
    logic                       above;
    logic                       at_black;
    logic                       at_white;
    logic [bres_pkg::SUM_W:0]   lane_sum [bres_pkg::NUM_CH];

    function automatic bres_pkg::tally_t bump(input bres_pkg::tally_t t);
        return (t < bres_pkg::TALLY_CAP) ? t + 1'b1 : bres_pkg::TALLY_CAP;
    endfunction

    always_comb
    begin
        pix = '0;
        pix[bres_pkg::PIXEL_BITS-1:0] = pixel_value[bres_pkg::PIXEL_BITS-1:0];
        below = pix < black_level;
        above = !below && (pix > white_level);
        clipped = below ? black_level : (above ? white_level : pix);
        at_black = clipped == black_level;
        at_white = !at_black && (clipped == white_level);
        add = (clipped > black_level) ? clipped - black_level : '0;
    end

    always_comb
    begin
        stats_next = stats_reg;
        for (int i = 0; i < bres_pkg::NUM_CH; i++)
        begin
            lane_sum[i] = {1'b0, stats_reg.sums[i]} + (bres_pkg::SUM_W + 1)'(add);
        end
        if (clear)
        begin
            stats_next = '0;
        end
        else if (en)
        begin
            for (int i = 0; i < bres_pkg::NUM_CH; i++)
            begin
                if (color_index == bres_pkg::CH_W'(i))
                begin
                    stats_next.sums[i] = lane_sum[i][bres_pkg::SUM_W] ? '1
                                       : lane_sum[i][bres_pkg::SUM_W-1:0];
                end
            end
            if (below)
            begin
                stats_next.below_black = bump(stats_reg.below_black);
            end
            if (above)
            begin
                stats_next.above_white = bump(stats_reg.above_white);
            end
            if (at_black)
            begin
                stats_next.at_black = bump(stats_reg.at_black);
            end
            if (at_white)
            begin
                stats_next.at_white = bump(stats_reg.at_white);
            end
            stats_next.total = bump(stats_reg.total);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg <= '0;
        end
        else
        begin
            stats_reg <= stats_next;
        end
    end

    assign stats = stats_reg;

endmodule

>>> rtl/bres_div.sv
// Shared restoring divider: floor(sum * 1024 / total), saturated, one bit a cycle.
// Quotient is 0 when total is 0. Depends on bres_pkg.
module bres_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  bres_pkg::sum_t        dividend,
    input  bres_pkg::tally_t      divisor,
    output logic                  done,
    output bres_pkg::mean_t       quotient
);

    localparam int HI_LSB = bres_pkg::MEAN_W - bres_pkg::MEAN_SHIFT;

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [bres_pkg::STEP_W-1:0]       step_reg, step_next;
    bres_pkg::tally_t                  rem_reg, rem_next;
    bres_pkg::tally_t                  dvs_reg, dvs_next;
    logic [bres_pkg::MEAN_W-1:0]       lo_reg, lo_next;
    bres_pkg::mean_t                   q_reg, q_next;

    logic [bres_pkg::TALLY_W:0]        trial;
    logic                              fits;
    logic                              ovf;

    always_comb
    begin
        trial = {rem_reg, lo_reg[bres_pkg::MEAN_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
        ovf   = (bres_pkg::TALLY_W + 1)'(dividend[bres_pkg::SUM_W-1:HI_LSB])
                >= {1'b0, divisor};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        if (start)
        begin
            dvs_next = divisor;
            rem_next = bres_pkg::TALLY_W'(dividend[bres_pkg::SUM_W-1:HI_LSB]);
            lo_next  = {dividend[HI_LSB-1:0], {bres_pkg::MEAN_SHIFT{1'b0}}};
            q_next   = '0;
            if (divisor == '0)
            begin
                done_next = 1'b1;
            end
            else if (ovf)
            begin
                q_next    = '1;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                step_next = bres_pkg::STEP_W'(bres_pkg::MEAN_W);
            end
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? bres_pkg::TALLY_W'(trial - {1'b0, dvs_reg})
                             : bres_pkg::TALLY_W'(trial);
            lo_next   = {lo_reg[bres_pkg::MEAN_W-2:0], 1'b0};
            q_next    = {q_reg[bres_pkg::MEAN_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == bres_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
